[hw/rtl/jss_pkg.sv]
// Package for the iterative linear solver: payload structs, opcodes,
// controller states and the command/status bundles. No dependencies.
package jss_pkg;

    localparam int MaxVarsDefault = 8;
    localparam int ValW = 32;

    typedef enum logic [1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_LOAD_EST  = 2'd1,
        OP_SWEEP     = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  row_index;
        logic [3:0]  col_index;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  var_index;
        logic [31:0] estimate;
        logic        last;
        logic        zero_pivot_error;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_INIT,
        ST_ROW_DIAG,
        ST_MAC,
        ST_MAC_WAIT,
        ST_DIV,
        ST_EMIT,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic row_init;   // load acc with rhs, latch diag
        logic mac_issue;  // read coef/estimate for column
        logic mac_acc;    // accumulate registered product
        logic div_start;
        logic emit;
        logic emit_err;
        logic commit;     // copy fresh into current, current into previous
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic diag_zero;
    } t_status;

endpackage

[hw/rtl/jss_datapath.sv]
// Datapath: coefficient and estimate stores, multiply-accumulate and a
// bit-serial divider. Depends on jss_pkg.
module jss_datapath import jss_pkg::*; #(
    parameter int MAX_VARS = MaxVarsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  t_in_item                    i_item,
    input  t_cmd                        i_cmd,
    input  logic [$clog2(MAX_VARS)-1:0] i_row,
    input  logic [$clog2(MAX_VARS)-1:0] i_col,
    input  logic [$clog2(MAX_VARS+1)-1:0] i_n,
    input  logic                        i_seidel,
    output t_status                     o_status,
    output logic                        o_res_valid,
    output t_out_item                   o_res
);
    localparam int IW = $clog2(MAX_VARS);
    localparam int NW = $clog2(MAX_VARS + 1);
    localparam int RW = MAX_VARS + 1;
    localparam int DEPTH = MAX_VARS * RW;
    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] w_waddr, w_raddr, w_ld_addr;
    logic          w_we;
    logic [31:0]   w_coef;

    assign w_ld_addr = AW'(i_item.row_index) * AW'(RW) + AW'(i_item.col_index);
    assign w_we = i_load && i_item.operation == OP_LOAD_COEF
        && 32'(i_item.row_index) < MAX_VARS && 32'(i_item.col_index) <= MAX_VARS;
    assign w_waddr = w_ld_addr;

    always_comb begin
        if (i_cmd.row_init) begin
            w_raddr = AW'(i_row) * AW'(RW) + AW'(i_n);
        end else if (i_cmd.mac_issue) begin
            w_raddr = AW'(i_row) * AW'(RW) + AW'(i_col);
        end else begin
            w_raddr = AW'(i_row) * AW'(RW) + AW'(i_row);
        end
    end

    jss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_item.value),
        .i_raddr(w_raddr),
        .o_rdata(w_coef)
    );

    logic [31:0] r_cur [MAX_VARS];
    logic [31:0] r_prev [MAX_VARS];
    logic [31:0] r_fresh [MAX_VARS];
    logic [31:0] r_xsrc;
    logic [1:0]  r_phase;       // 1 = rhs arriving, 2 = diag arriving
    logic [63:0] r_acc;
    logic signed [31:0] r_diag;
    logic signed [63:0] r_prod;
    logic        r_pvalid;
    logic        r_prod_valid;
    logic        r_diag_zero;

    wire est_we = i_load && i_item.operation == OP_LOAD_EST
        && 32'(i_item.row_index) < MAX_VARS;

    always_ff @(posedge i_clk) begin
        if (est_we) begin
            r_cur[IW'(i_item.row_index)] <= i_item.value;
        end
        if (i_cmd.commit) begin
            for (int k = 0; k < MAX_VARS; k++) begin
                r_prev[k] <= r_cur[k];
                if (32'(k) < 32'(i_n)) begin
                    r_cur[k] <= r_fresh[k];
                end
            end
        end
        r_xsrc <= (i_seidel && i_col < i_row) ? r_fresh[i_col] : r_cur[i_col];
    end

    // row init: the row_init cycle reads rhs, next cycle reads diag (default address)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pvalid <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            r_phase <= i_cmd.row_init ? 2'd1 : (r_phase == 2'd1 ? 2'd2 : 2'd0);
            r_pvalid <= i_cmd.mac_issue;
            r_prod_valid <= r_pvalid;
        end
    end

    logic signed [63:0] w_full;
    assign w_full = $signed(w_coef) * $signed(r_xsrc);

    always_ff @(posedge i_clk) begin
        if (r_phase == 2'd1) begin
            r_acc <= {{32{w_coef[31]}}, w_coef};
        end else if (i_cmd.mac_acc && r_prod_valid) begin
            r_acc <= r_acc - r_prod;
        end
        if (r_phase == 2'd2) begin
            r_diag <= $signed(w_coef);
            r_diag_zero <= (w_coef == '0);
        end
        if (r_pvalid) begin
            // truncate toward zero to Q16.16
            r_prod <= (w_full[63] && w_full[15:0] != '0)
                ? (w_full >>> 16) + 64'sd1 : (w_full >>> 16);
        end
    end

    // Divider: trunc(acc*65536/diag) on magnitudes, 1 bit per cycle.
    localparam int QW = 70;
    logic [QW-1:0] r_num;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [6:0]    r_cnt;
    logic          r_busy, r_neg, r_done;
    logic [QW-1:0] w_nshift;
    logic [33:0]   w_rtry;

    assign w_rtry = {r_rem, r_num[QW-1]} - {2'b0, r_den};
    assign w_nshift = {r_num[QW-2:0], ~w_rtry[33]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num <= QW'(r_acc[63] ? 64'(-r_acc) : r_acc) << 16;
            r_den <= r_diag[31] ? 32'(-r_diag) : r_diag;
            r_rem <= '0;
            r_neg <= r_acc[63] ^ r_diag[31];
        end else if (r_busy) begin
            r_rem <= w_rtry[33] ? {r_rem[31:0], r_num[QW-1]} : w_rtry[32:0];
            r_num <= w_nshift;
        end
    end

    logic [31:0] w_sat;
    always_comb begin
        if (r_num[QW-1:31] != '0) begin
            w_sat = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_neg) begin
            w_sat = 32'(-{1'b0, r_num[30:0]});
        end else begin
            w_sat = {1'b0, r_num[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && !i_cmd.emit_err) begin
            r_fresh[i_row] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_res.var_index <= 3'(i_row);
            o_res.estimate <= i_cmd.emit_err ? '0 : w_sat;
            o_res.last <= i_cmd.emit_err || (NW'(i_row) + NW'(1) == i_n);
            o_res.zero_pivot_error <= i_cmd.emit_err;
        end
    end

    assign o_status.div_done = r_done;
    assign o_status.diag_zero = r_diag_zero;
endmodule

[hw/rtl/jss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/jss_ctrl.sv]
// Sweep controller: walks rows and columns, sequences MAC and divider.
// Depends on jss_pkg.
module jss_ctrl import jss_pkg::*; #(
    parameter int MAX_VARS = MaxVarsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sweep,
    input  logic [$clog2(MAX_VARS+1)-1:0] i_n,
    input  t_status                       i_status,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_VARS)-1:0]   o_row,
    output logic [$clog2(MAX_VARS)-1:0]   o_col,
    output logic                          o_busy
);
    localparam int IW = $clog2(MAX_VARS);
    localparam int NW = $clog2(MAX_VARS + 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_row, n_row, r_col, n_col;
    logic [1:0] r_wait, n_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row <= '0;
            r_col <= '0;
            r_wait <= '0;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_col <= n_col;
            r_wait <= n_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_col = r_col;
        n_wait = r_wait;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_sweep) begin
                    n_row = '0;
                    n_state = ST_ROW_INIT;
                end
            end
            ST_ROW_INIT: begin
                o_cmd.row_init = 1'b1;
                n_col = '0;
                n_state = ST_ROW_DIAG;
            end
            ST_ROW_DIAG: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mac_acc = 1'b1;
                o_cmd.mac_issue = (r_col != r_row);
                if (NW'(r_col) + NW'(1) == i_n) begin
                    n_wait = 2'd3;
                    n_state = ST_MAC_WAIT;
                end else begin
                    n_col = r_col + IW'(1);
                end
            end
            ST_MAC_WAIT: begin
                o_cmd.mac_acc = 1'b1;
                n_wait = r_wait - 2'd1;
                if (r_wait == 2'd1) begin
                    if (i_status.diag_zero) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_DIV;
                        o_cmd.div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_err = i_status.diag_zero;
                if (i_status.diag_zero) begin
                    n_state = ST_IDLE;
                end else if (NW'(r_row) + NW'(1) == i_n) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_row = r_row + IW'(1);
                    n_state = ST_ROW_INIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_busy = (r_state != ST_IDLE);
endmodule

[hw/rtl/jacobi_seidel_iterative_solver_top.sv]
// Jacobi / Gauss-Seidel iterative solver, top level.
// Uses jss_pkg, jss_ctrl, jss_datapath, jss_ram.
//
// Usage:
//  Items enter on start/i_item when busy is low. Loads (coefficient,
//  right-hand side, initial estimate) give no result.
//  A sweep emits one result per variable on o_res_valid/o_res, one cycle
//  each, last one flagged; a zero diagonal ends the sweep with an error
//  result and leaves the estimates unchanged.
//  Per variable a sweep runs row setup (ST_ROW_INIT, ST_ROW_DIAG), the MAC
//  over the columns, a pipeline drain (ST_MAC_WAIT), the bit-serial divider
//  (70 quotient bits) and an emit; a completed sweep ends with a commit.
//  Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index/i_cfg_data;
//  index 0 method (1 = Gauss-Seidel), index 1 variable count. Write only
//  when idle.
//  Reset (synchronous, active low) returns to idle with Jacobi and a variable
//  count of 8 (clamped to MAX_VARS); stores are undefined until loaded.
//  Results cannot be held off by the receiver; no result is ever dropped.
module jacobi_seidel_iterative_solver_top import jss_pkg::*; #(
    parameter int MAX_VARS = MaxVarsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [3:0] i_cfg_data
);
    localparam int IW = $clog2(MAX_VARS);
    localparam int NW = $clog2(MAX_VARS + 1);

    logic       r_method;
    logic [3:0] r_count;
    logic [NW-1:0] w_n;
    t_cmd    w_cmd;
    t_status w_status;
    logic [IW-1:0] w_row, w_col;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= 1'b0;
            r_count <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_METHOD: r_method <= i_cfg_data[0];
                CFG_COUNT:  r_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_count) > MAX_VARS) begin
            w_n = NW'(MAX_VARS);
        end else begin
            w_n = NW'(r_count);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_accept = start && !busy;

    jss_ctrl #(.MAX_VARS(MAX_VARS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sweep (w_accept && i_item.operation == OP_SWEEP),
        .i_n     (w_n),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .o_row   (w_row),
        .o_col   (w_col),
        .o_busy  (busy)
    );

    jss_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .i_row      (w_row),
        .i_col      (w_col),
        .i_n        (w_n),
        .i_seidel   (r_method),
        .o_status   (w_status),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );
endmodule
